// ===== rtl/min_heap_priority_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the min-heap priority queue.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants of the min-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

    // Number of heap slots and stored key width.
    localparam int CAPACITY  = 1024;
    localparam int KEY_WIDTH = 32;

    // Fixed widths of the request and result fields.
    localparam int VAL_W = 32;
    localparam int POS_W = 11;

    // Slot index and element count share one width; slot zero is unused.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic signed [KEY_WIDTH-1:0] t_key;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_EXTRACT  = 2'd1,
        OP_DECREASE = 2'd2,
        OP_PEEK     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DEC_CMP,
        S_EXT_LOAD,
        S_DN_RD,
        S_DN_CMP,
        S_PEEK,
        S_DONE
    } t_state;

    // Finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic               valid;
        logic [VAL_W-1:0]   value;
        t_status            status;
        logic [POS_W-1:0]   count;
    } t_result;

endpackage

// ===== rtl/min_heap_priority_queue_top.sv =====
// A request refused at once goes straight to the done state; a peek or a refused decrease first
// passes the peek or decrease-compare state, and an insert, an extract or an accepted decrease
// sifts the heap level by level. One request at a time: the next is taken in the cycle after
// the previous result is registered; each heap level takes a RAM read state and a compare/write
// state on the heap RAM, so a full sift is the slowest request.
// Reset clears the element count and the handshake state; the heap RAM is not cleared.
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top
// Binary min-heap priority queue with insert, extract, decrease-key and peek.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_operation,
    input  logic signed [hpq_pkg::VAL_W-1:0] i_key,
    input  logic [hpq_pkg::POS_W-1:0]        i_position,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [hpq_pkg::VAL_W-1:0] o_value,
    output logic [1:0]                       o_status,
    output logic [hpq_pkg::POS_W-1:0]        o_count
);

    hpq_pkg::t_result w_res;
    logic             w_take;
    logic             r_out_valid;
    logic [hpq_pkg::VAL_W-1:0] r_value;
    hpq_pkg::t_status r_status;
    logic [hpq_pkg::POS_W-1:0] r_count;

    hpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_position  (i_position),
        .o_ready     (o_in_ready),
        .o_res       (w_res),
        .i_res_take  (w_take)
    );

    // The output register takes a new beat when empty or being drained.
    assign w_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid && w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_take) begin
            r_value  <= w_res.value;
            r_status <= w_res.status;
            r_count  <= w_res.count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;
    assign o_count     = r_count;

endmodule

// ===== rtl/hpq_ram.sv =====
// ----------------------------------------------------------------------------
// hpq_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two read ports, each registered.
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/hpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpq_ctrl
// Request sequencer: decodes a request and walks the heap RAM level by level.
// ----------------------------------------------------------------------------
`include "min_heap_priority_queue_top_macros.svh"

module hpq_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [1:0]                     i_operation,
    input  logic signed [hpq_pkg::VAL_W-1:0] i_key,
    input  logic [hpq_pkg::POS_W-1:0]      i_position,
    output logic                           o_ready,
    output hpq_pkg::t_result               o_res,
    input  logic                           i_res_take
);

    localparam int CNT_W = hpq_pkg::CNT_W;
    localparam int CMP_W = hpq_pkg::CMP_W;

    hpq_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    hpq_pkg::t_key    r_cur, n_cur;
    logic [hpq_pkg::VAL_W-1:0] r_value, n_value;
    hpq_pkg::t_status r_status, n_status;

    logic             w_accept;
    hpq_pkg::t_op     w_op;
    hpq_pkg::t_key    w_key;
    logic             w_full;
    logic             w_empty;
    logic             w_pos_ok;
    logic [CNT_W:0]   w_left;
    logic [CNT_W:0]   w_right;
    logic [CNT_W:0]   w_cnt_ext;
    logic [CNT_W-1:0] w_sel_idx;
    hpq_pkg::t_key    w_sel_key;
    hpq_pkg::t_key    w_rd_a;
    hpq_pkg::t_key    w_rd_b;

    logic             w_we;
    logic [CNT_W-1:0] w_waddr;
    hpq_pkg::t_key    w_wdata;
    logic [CNT_W-1:0] w_raddr_a;
    logic [CNT_W-1:0] w_raddr_b;

    // Heap storage, slots 1 to CAPACITY.
    hpq_ram #(
        .WIDTH (hpq_pkg::KEY_WIDTH),
        .DEPTH (hpq_pkg::CAPACITY + 1)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // Request decode.
    assign o_ready   = (r_state == hpq_pkg::S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_op      = hpq_pkg::t_op'(i_operation);
    assign w_key     = hpq_pkg::t_key'(i_key);
    assign w_full    = (r_cnt >= CNT_W'(hpq_pkg::CAPACITY));
    assign w_empty   = (r_cnt == '0);
    assign w_pos_ok  = (i_position != '0) && (CMP_W'(i_position) <= CMP_W'(r_cnt));

    // Child slots of the current hole.
    assign w_left    = {r_idx, 1'b0};
    assign w_right   = {r_idx, 1'b1};
    assign w_cnt_ext = {1'b0, r_cnt};

    // Smallest of the hole key and its children, left child first on a tie.
    always_comb begin
        w_sel_idx = r_idx;
        w_sel_key = r_cur;
        if ((w_left <= w_cnt_ext) && (w_rd_a < w_sel_key)) begin
            w_sel_idx = w_left[CNT_W-1:0];
            w_sel_key = w_rd_a;
        end
        if ((w_right <= w_cnt_ext) && (w_rd_b < w_sel_key)) begin
            w_sel_idx = w_right[CNT_W-1:0];
            w_sel_key = w_rd_b;
        end
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpq_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cur    <= n_cur;
        r_value  <= n_value;
        r_status <= n_status;
    end

    // Next state, RAM accesses and result fields.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_value   = r_value;
        n_status  = r_status;
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = r_cur;
        w_raddr_a = CNT_W'(1);
        w_raddr_b = r_cnt;

        unique case (r_state)
            hpq_pkg::S_IDLE: begin
                if (w_op == hpq_pkg::OP_DECREASE) begin
                    w_raddr_a = CNT_W'(i_position);
                end
                if (w_accept) begin
                    n_value  = '0;
                    n_status = hpq_pkg::ST_OK;
                    unique case (w_op)
                        hpq_pkg::OP_INSERT: begin
                            if (w_full) begin
                                n_status = hpq_pkg::ST_FULL;
                                n_state  = hpq_pkg::S_DONE;
                            end else begin
                                n_cnt   = r_cnt + 1'b1;
                                n_idx   = r_cnt + 1'b1;
                                n_cur   = w_key;
                                n_state = hpq_pkg::S_UP_RD;
                            end
                        end
                        hpq_pkg::OP_EXTRACT: begin
                            if (w_empty) begin
                                n_status = hpq_pkg::ST_EMPTY;
                                n_state  = hpq_pkg::S_DONE;
                            end else begin
                                n_state = hpq_pkg::S_EXT_LOAD;
                            end
                        end
                        hpq_pkg::OP_DECREASE: begin
                            if (!w_pos_ok) begin
                                n_status = hpq_pkg::ST_IGNORED;
                                n_state  = hpq_pkg::S_DONE;
                            end else begin
                                n_idx   = CNT_W'(i_position);
                                n_cur   = w_key;
                                n_state = hpq_pkg::S_DEC_CMP;
                            end
                        end
                        default: begin
                            if (w_empty) begin
                                n_status = hpq_pkg::ST_EMPTY;
                                n_state  = hpq_pkg::S_DONE;
                            end else begin
                                n_state = hpq_pkg::S_PEEK;
                            end
                        end
                    endcase
                end
            end

            // Fetch the parent of the hole, or settle the key at the root.
            hpq_pkg::S_UP_RD: begin
                w_raddr_a = r_idx >> 1;
                if (r_idx == CNT_W'(1)) begin
                    w_we    = 1'b1;
                    n_state = hpq_pkg::S_DONE;
                end else begin
                    n_state = hpq_pkg::S_UP_CMP;
                end
            end

            // Move the parent down into the hole, or settle the key here.
            hpq_pkg::S_UP_CMP: begin
                w_we = 1'b1;
                if (r_cur < w_rd_a) begin
                    w_wdata = w_rd_a;
                    n_idx   = r_idx >> 1;
                    n_state = hpq_pkg::S_UP_RD;
                end else begin
                    n_state = hpq_pkg::S_DONE;
                end
            end

            // A larger key than the stored one is refused.
            hpq_pkg::S_DEC_CMP: begin
                if (w_rd_a < r_cur) begin
                    n_status = hpq_pkg::ST_IGNORED;
                    n_state  = hpq_pkg::S_DONE;
                end else begin
                    n_state = hpq_pkg::S_UP_RD;
                end
            end

            // Root is the result; the last element becomes the root hole key.
            hpq_pkg::S_EXT_LOAD: begin
                n_value = hpq_pkg::VAL_W'(w_rd_a);
                n_cur   = w_rd_b;
                n_cnt   = r_cnt - 1'b1;
                n_idx   = CNT_W'(1);
                n_state = hpq_pkg::S_DN_RD;
            end

            // Fetch both children, or settle the key at a leaf.
            hpq_pkg::S_DN_RD: begin
                w_raddr_a = w_left[CNT_W-1:0];
                w_raddr_b = w_right[CNT_W-1:0];
                if (w_left > w_cnt_ext) begin
                    w_we    = 1'b1;
                    n_state = hpq_pkg::S_DONE;
                end else begin
                    n_state = hpq_pkg::S_DN_CMP;
                end
            end

            // Pull the smaller child up into the hole, or settle the key here.
            hpq_pkg::S_DN_CMP: begin
                w_we = 1'b1;
                if (w_sel_idx == r_idx) begin
                    n_state = hpq_pkg::S_DONE;
                end else begin
                    w_wdata = w_sel_key;
                    n_idx   = w_sel_idx;
                    n_state = hpq_pkg::S_DN_RD;
                end
            end

            hpq_pkg::S_PEEK: begin
                n_value = hpq_pkg::VAL_W'(w_rd_a);
                n_state = hpq_pkg::S_DONE;
            end

            hpq_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = hpq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = hpq_pkg::S_IDLE;
            end
        endcase
    end

    // Result handed to the output register.
    assign o_res.valid  = (r_state == hpq_pkg::S_DONE);
    assign o_res.value  = r_value;
    assign o_res.status = r_status;
    assign o_res.count  = hpq_pkg::POS_W'(r_cnt);

    // Checks on the sequencer.
    `HPQ_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n,
        w_accept && (w_op == hpq_pkg::OP_INSERT) && !w_full,
        r_cnt == $past(r_cnt) + 1'b1, "insert did not grow the count")
    `HPQ_ASSERT_SAME(a_write_slot, i_clk, i_rst_n,
        w_we, (w_waddr != '0) && (w_waddr <= CNT_W'(hpq_pkg::CAPACITY)),
        "heap write outside slots one to capacity")
    `HPQ_ASSERT_SAME(a_fail_value, i_clk, i_rst_n,
        o_res.valid && (o_res.status != hpq_pkg::ST_OK), o_res.value == '0,
        "failed request carries a nonzero value")
    `HPQ_ASSERT_NEXT(a_take_idle, i_clk, i_rst_n,
        o_res.valid && i_res_take, o_ready && $stable(r_cnt),
        "sequencer not idle after its result was taken")

endmodule
